// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the accumulation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define WOA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define WOA_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define WOA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define WOA_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- rtl/woa_pkg.sv -----
// Shared constants, types and divider step functions for the accumulation core.
`default_nettype none
package woa_pkg;
   localparam int PIXELS = 65536;
   localparam int PIX_AW = $clog2(PIXELS);
   localparam int STAGES = 8;
   localparam int CSR_AW = 3;
   localparam logic REG_SAMPLE_COUNT = 1'b0;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic              we;
      logic [PIX_AW-1:0] addr;
      logic [31:0]       data;
   } store_wr_type;

   typedef struct packed {
      logic [7:0]  rem;
      logic [16:0] quo;
      logic [16:0] dvd;
   } sdiv_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [7:0]  quo;
      logic [7:0]  dvd;
   } cdiv_type;

   // a * 65536 / 255, truncated: a*257 plus one for full scale
   function automatic logic [16:0] alpha_to_q16(logic [7:0] a);
      return {1'b0, a, 8'b0} + {9'b0, a} + {16'b0, (a == 8'hFF)};
   endfunction

   function automatic sdiv_type sdiv_step(sdiv_type x, logic [7:0] d);
      sdiv_type y;
      logic [8:0] t;
      t = {x.rem, x.dvd[16]};
      y.dvd = {x.dvd[15:0], 1'b0};
      if (t >= {1'b0, d}) begin
         y.rem = 8'(t - {1'b0, d});
         y.quo = {x.quo[15:0], 1'b1};
      end else begin
         y.rem = t[7:0];
         y.quo = {x.quo[15:0], 1'b0};
      end
      return y;
   endfunction

   function automatic cdiv_type cdiv_step(cdiv_type x, logic [16:0] d);
      cdiv_type y;
      logic [17:0] t;
      t = {x.rem, x.dvd[7]};
      y.dvd = {x.dvd[6:0], 1'b0};
      if (t >= {1'b0, d}) begin
         y.rem = 17'(t - {1'b0, d});
         y.quo = {x.quo[6:0], 1'b1};
      end else begin
         y.rem = t[16:0];
         y.quo = {x.quo[6:0], 1'b0};
      end
      return y;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/woa_store.sv -----
// Frame store: one write port, one registered read port, clearing pass after reset.
`default_nettype none
module woa_store (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [woa_pkg::PIX_AW-1:0]  rd_addr,
   output logic [31:0]                      rd_data,
   input  wire woa_pkg::store_wr_type       wr,
   output logic                             clr_busy
);
   logic [31:0] mem [woa_pkg::PIXELS];
   logic [31:0] rd_ff;
   logic                       clr_busy_ff;
   logic [woa_pkg::PIX_AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == woa_pkg::PIX_AW'(woa_pkg::PIXELS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_ff;
   assign clr_busy = clr_busy_ff;
endmodule
`default_nettype wire

// ----- rtl/woa_blend.sv -----
// Eight-stage blend pipeline: source alpha divide, over weights, color divide.
`default_nettype none
module woa_blend (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_vld,
   input  wire logic [15:0]                 in_idx,
   input  wire logic                        in_first,
   input  wire logic [7:0]                  in_red,
   input  wire logic [7:0]                  in_green,
   input  wire logic [7:0]                  in_blue,
   input  wire logic [7:0]                  in_alpha,
   input  wire logic [7:0]                  sample_count,
   input  wire logic [31:0]                 rd_data,
   input  wire logic                        out_adv,
   output logic                             in_adv,
   output logic                             last_vld,
   output logic [15:0]                      last_idx,
   output logic [31:0]                      last_pix,
   output logic [woa_pkg::STAGES-1:0]       busy_vld,
   output logic [woa_pkg::STAGES-1:0][15:0] busy_idx
);
   typedef struct packed {
      logic [15:0] idx;
      logic [7:0]  sr;
      logic [7:0]  sg;
      logic [7:0]  sb;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic              first;
      woa_pkg::sdiv_type sdv;
      logic [7:0]        n;
   } s1_type;

   typedef struct packed {
      tag_type           tag;
      logic [31:0]       dpix;
      logic [16:0]       dst_a;
      woa_pkg::sdiv_type sdv;
      logic [7:0]        n;
   } front_type;

   typedef struct packed {
      tag_type     tag;
      logic [31:0] dpix;
      logic [16:0] src_a;
      logic [16:0] dst_w;
   } s5_type;

   typedef struct packed {
      logic [15:0] idx;
      logic [31:0] dpix;
      logic [16:0] out_a;
      logic [23:0] nr;
      logic [23:0] ng;
      logic [23:0] nb;
   } s6_type;

   typedef struct packed {
      logic [15:0]       idx;
      logic [31:0]       dpix;
      logic [16:0]       out_a;
      logic [7:0]        alpha;
      woa_pkg::cdiv_type cr;
      woa_pkg::cdiv_type cg;
      woa_pkg::cdiv_type cb;
   } s7_type;

   typedef struct packed {
      logic [15:0] idx;
      logic [31:0] pix;
   } s8_type;

   logic [woa_pkg::STAGES-1:0] vld_ff;
   logic [woa_pkg::STAGES-1:0] adv;
   s1_type    s1_ff, s1_in;
   front_type s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in;
   s5_type    s5_ff, s5_in;
   s6_type    s6_ff, s6_in;
   s7_type    s7_ff, s7_in;
   s8_type    s8_ff, s8_in;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[woa_pkg::STAGES-1] = !vld_ff[woa_pkg::STAGES-1] || out_adv;
      for (int k = woa_pkg::STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_vld;
         end
         for (int k = 1; k < woa_pkg::STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      s1_in.tag.idx = in_idx;
      s1_in.tag.sr  = in_red;
      s1_in.tag.sg  = in_green;
      s1_in.tag.sb  = in_blue;
      s1_in.first   = in_first;
      s1_in.sdv.rem = '0;
      s1_in.sdv.quo = '0;
      s1_in.sdv.dvd = woa_pkg::alpha_to_q16(in_alpha);
      s1_in.n       = (sample_count == 8'd0) ? 8'd1 : sample_count;
   end

   always_comb begin
      s2_in.tag   = s1_ff.tag;
      s2_in.n     = s1_ff.n;
      s2_in.dpix  = s1_ff.first ? 32'd0 : rd_data;
      s2_in.dst_a = woa_pkg::alpha_to_q16(s2_in.dpix[31:24]);
      s2_in.sdv   = s1_ff.sdv;
      for (int k = 0; k < 6; k++) begin
         s2_in.sdv = woa_pkg::sdiv_step(s2_in.sdv, s1_ff.n);
      end
   end

   always_comb begin
      s3_in = s2_ff;
      for (int k = 0; k < 6; k++) begin
         s3_in.sdv = woa_pkg::sdiv_step(s3_in.sdv, s2_ff.n);
      end
   end

   always_comb begin
      s4_in = s3_ff;
      for (int k = 0; k < 5; k++) begin
         s4_in.sdv = woa_pkg::sdiv_step(s4_in.sdv, s3_ff.n);
      end
   end

   logic [33:0] wprod;
   always_comb begin
      wprod       = {17'd0, s4_ff.dst_a} * {17'd0, woa_pkg::ONE_Q16 - s4_ff.sdv.quo};
      s5_in.tag   = s4_ff.tag;
      s5_in.dpix  = s4_ff.dpix;
      s5_in.src_a = s4_ff.sdv.quo;
      s5_in.dst_w = wprod[32:16];
   end

   logic [25:0] sum_r, sum_g, sum_b;
   always_comb begin
      sum_r = {1'b0, 8'd0, s5_ff.tag.sr} * {9'd0, s5_ff.src_a}
            + {1'b0, 8'd0, s5_ff.dpix[7:0]} * {9'd0, s5_ff.dst_w};
      sum_g = {1'b0, 8'd0, s5_ff.tag.sg} * {9'd0, s5_ff.src_a}
            + {1'b0, 8'd0, s5_ff.dpix[15:8]} * {9'd0, s5_ff.dst_w};
      sum_b = {1'b0, 8'd0, s5_ff.tag.sb} * {9'd0, s5_ff.src_a}
            + {1'b0, 8'd0, s5_ff.dpix[23:16]} * {9'd0, s5_ff.dst_w};
      s6_in.idx   = s5_ff.tag.idx;
      s6_in.dpix  = s5_ff.dpix;
      s6_in.out_a = s5_ff.src_a + s5_ff.dst_w;
      s6_in.nr    = sum_r[23:0];
      s6_in.ng    = sum_g[23:0];
      s6_in.nb    = sum_b[23:0];
   end

   logic [24:0] aprod;
   always_comb begin
      aprod        = {8'd0, s6_ff.out_a} * 25'd255;
      s7_in.idx    = s6_ff.idx;
      s7_in.dpix   = s6_ff.dpix;
      s7_in.out_a  = s6_ff.out_a;
      s7_in.alpha  = aprod[23:16];
      // numerator stays below 256 * out_a, so the high part starts as remainder
      s7_in.cr.rem = {1'b0, s6_ff.nr[23:8]};
      s7_in.cr.quo = '0;
      s7_in.cr.dvd = s6_ff.nr[7:0];
      s7_in.cg.rem = {1'b0, s6_ff.ng[23:8]};
      s7_in.cg.quo = '0;
      s7_in.cg.dvd = s6_ff.ng[7:0];
      s7_in.cb.rem = {1'b0, s6_ff.nb[23:8]};
      s7_in.cb.quo = '0;
      s7_in.cb.dvd = s6_ff.nb[7:0];
      for (int k = 0; k < 4; k++) begin
         s7_in.cr = woa_pkg::cdiv_step(s7_in.cr, s6_ff.out_a);
         s7_in.cg = woa_pkg::cdiv_step(s7_in.cg, s6_ff.out_a);
         s7_in.cb = woa_pkg::cdiv_step(s7_in.cb, s6_ff.out_a);
      end
   end

   woa_pkg::cdiv_type fr, fg, fb;
   always_comb begin
      fr = s7_ff.cr;
      fg = s7_ff.cg;
      fb = s7_ff.cb;
      for (int k = 0; k < 4; k++) begin
         fr = woa_pkg::cdiv_step(fr, s7_ff.out_a);
         fg = woa_pkg::cdiv_step(fg, s7_ff.out_a);
         fb = woa_pkg::cdiv_step(fb, s7_ff.out_a);
      end
      s8_in.idx = s7_ff.idx;
      // transparent result keeps the destination pixel, which is zero for a first sample
      s8_in.pix = (s7_ff.out_a != 17'd0) ? {s7_ff.alpha, fb.quo, fg.quo, fr.quo}
                                         : s7_ff.dpix;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) s1_ff <= s1_in;
      if (adv[1]) s2_ff <= s2_in;
      if (adv[2]) s3_ff <= s3_in;
      if (adv[3]) s4_ff <= s4_in;
      if (adv[4]) s5_ff <= s5_in;
      if (adv[5]) s6_ff <= s6_in;
      if (adv[6]) s7_ff <= s7_in;
      if (adv[7]) s8_ff <= s8_in;
   end

   assign in_adv      = adv[0];
   assign last_vld    = vld_ff[woa_pkg::STAGES-1];
   assign last_idx    = s8_ff.idx;
   assign last_pix    = s8_ff.pix;
   assign busy_vld    = vld_ff;
   assign busy_idx[0] = s1_ff.tag.idx;
   assign busy_idx[1] = s2_ff.tag.idx;
   assign busy_idx[2] = s3_ff.tag.idx;
   assign busy_idx[3] = s4_ff.tag.idx;
   assign busy_idx[4] = s5_ff.tag.idx;
   assign busy_idx[5] = s6_ff.idx;
   assign busy_idx[6] = s7_ff.idx;
   assign busy_idx[7] = s8_ff.idx;
endmodule
`default_nettype wire

// ----- rtl/weighted_over_accumulate_core.sv -----
// Top level: register port, same-pixel interlock, frame store, blend pipeline, result register.
//
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid/req_stall  | pixel index, first flag, sample RGBA
//  rsp      | out       | rsp_valid/rsp_stall  | pixel index, accumulated RGBA
//  csr      | in/out    | APB psel/penable     | sample_count at byte address 0
//
// One item per cycle while req_stall is low; each item passes through the blend pipeline and the result register.
// An item whose pixel is still in the pipeline waits until that earlier
// update is written to the store; an rsp stall lengthens the wait.
// After reset all 65536 store words are cleared with req_stall high.
// rsp_stall holds the result register; pipeline bubbles keep filling behind it.
`default_nettype none
`include "assert_macros.svh"
module weighted_over_accumulate_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [15:0]                 req_pixel_index,
   input  wire logic                        req_first_sample,
   input  wire logic [7:0]                  req_src_red,
   input  wire logic [7:0]                  req_src_green,
   input  wire logic [7:0]                  req_src_blue,
   input  wire logic [7:0]                  req_src_alpha,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [15:0]                      rsp_out_index,
   output logic [7:0]                       rsp_acc_red,
   output logic [7:0]                       rsp_acc_green,
   output logic [7:0]                       rsp_acc_blue,
   output logic [7:0]                       rsp_acc_alpha,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [woa_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   logic [7:0] sample_count_ff;
   logic       rsp_valid_ff;
   logic [15:0] rsp_idx_ff;
   logic [31:0] rsp_pix_ff;

   logic accept, out_adv, in_adv, clr_busy, hit, last_vld;
   logic [15:0] last_idx;
   logic [31:0] last_pix, rd_data;
   logic [woa_pkg::STAGES-1:0]       busy_vld;
   logic [woa_pkg::STAGES-1:0][15:0] busy_idx;
   woa_pkg::store_wr_type wr;

   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, sample_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= 8'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == woa_pkg::REG_SAMPLE_COUNT) begin
         sample_count_ff <= csr_pwdata[7:0];
      end
   end

   // hold a pixel whose earlier update is not yet written back
   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < woa_pkg::STAGES; k++) begin
         if (busy_vld[k] && busy_idx[k] == req_pixel_index) begin
            hit = 1'b1;
         end
      end
   end

   assign req_stall = clr_busy || !in_adv || hit;
   assign accept    = req_valid && !req_stall;
   assign out_adv   = !rsp_valid_ff || !rsp_stall;

   assign wr.we   = last_vld && out_adv;
   assign wr.addr = last_idx;
   assign wr.data = last_pix;

   woa_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_pixel_index),
      .rd_data  (rd_data),
      .wr       (wr),
      .clr_busy (clr_busy)
   );

   woa_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (accept),
      .in_idx       (req_pixel_index),
      .in_first     (req_first_sample),
      .in_red       (req_src_red),
      .in_green     (req_src_green),
      .in_blue      (req_src_blue),
      .in_alpha     (req_src_alpha),
      .sample_count (sample_count_ff),
      .rd_data      (rd_data),
      .out_adv      (out_adv),
      .in_adv       (in_adv),
      .last_vld     (last_vld),
      .last_idx     (last_idx),
      .last_pix     (last_pix),
      .busy_vld     (busy_vld),
      .busy_idx     (busy_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= last_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_idx_ff <= last_idx;
         rsp_pix_ff <= last_pix;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_acc_red   = rsp_pix_ff[7:0];
   assign rsp_acc_green = rsp_pix_ff[15:8];
   assign rsp_acc_blue  = rsp_pix_ff[23:16];
   assign rsp_acc_alpha = rsp_pix_ff[31:24];

   `WOA_ASSERT_NEVER(a_no_transfer_while_clearing, clock, reset, accept && clr_busy)
   `WOA_ASSERT_NEVER(a_no_store_write_while_clearing, clock, reset, wr.we && clr_busy)
   `WOA_ASSERT_IMPLY(a_no_read_of_pending_pixel, clock, reset, accept && wr.we,
                     wr.addr != req_pixel_index)
   `WOA_ASSERT_IMPLY(a_write_fills_result, clock, reset, wr.we, out_adv && last_vld)
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the weighted over accumulation core: directed and random RGBA samples and checks.
`default_nettype none
module tb;
   typedef struct {
      logic [15:0] index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } pixel_out_type;

   class blend_scoreboard;
      logic [31:0]   frame_copy [int];
      logic [7:0]    weight_count;
      pixel_out_type pending [$];
      int            errors;

      function new();
         weight_count = 8'd1;
         errors = 0;
      endfunction

      function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d,
                                       longint src_a, longint dst_w, longint out_a);
         longint v;
         v = (s * src_a + d * dst_w) / out_a;
         return v > 255 ? 8'd255 : v[7:0];
      endfunction

      function void note_sample(logic [15:0] idx, logic first, logic [7:0] sr,
                                logic [7:0] sg, logic [7:0] sb, logic [7:0] sa);
         logic [31:0] pix;
         longint n, src_a, dst_a, dst_w, out_a, av;
         pixel_out_type r;
         pix = (first || !frame_copy.exists(idx)) ? 32'd0 : frame_copy[idx];
         n = (weight_count == 0) ? 1 : weight_count;
         src_a = (longint'(sa) * 65536) / (255 * n);
         dst_a = (longint'(pix[31:24]) * 65536) / 255;
         dst_w = (dst_a * (65536 - src_a)) >> 16;
         out_a = src_a + dst_w;
         if (out_a != 0) begin
            av = (out_a * 255) >> 16;
            pix[7:0]   = mix_channel(sr, pix[7:0], src_a, dst_w, out_a);
            pix[15:8]  = mix_channel(sg, pix[15:8], src_a, dst_w, out_a);
            pix[23:16] = mix_channel(sb, pix[23:16], src_a, dst_w, out_a);
            pix[31:24] = av > 255 ? 8'd255 : av[7:0];
         end
         frame_copy[idx] = pix;
         r.index = idx;
         r.red = pix[7:0];
         r.green = pix[15:8];
         r.blue = pix[23:16];
         r.alpha = pix[31:24];
         pending.push_back(r);
      endfunction

      function void check_result(pixel_out_type got);
         pixel_out_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result for index %0d", got.index);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.index !== exp.index) begin
            $error("out_index expected %0d got %0d", exp.index, got.index); errors++;
         end
         if (got.red !== exp.red) begin
            $error("acc_red expected %0d got %0d", exp.red, got.red); errors++;
         end
         if (got.green !== exp.green) begin
            $error("acc_green expected %0d got %0d", exp.green, got.green); errors++;
         end
         if (got.blue !== exp.blue) begin
            $error("acc_blue expected %0d got %0d", exp.blue, got.blue); errors++;
         end
         if (got.alpha !== exp.alpha) begin
            $error("acc_alpha expected %0d got %0d", exp.alpha, got.alpha); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_pixel_index = '0;
   logic req_first_sample = 1'b0;
   logic [7:0] req_src_red = '0, req_src_green = '0, req_src_blue = '0, req_src_alpha = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_out_index;
   logic [7:0] rsp_acc_red, rsp_acc_green, rsp_acc_blue, rsp_acc_alpha;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [woa_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   blend_scoreboard blend_sb = new();
   int hold_cycles = 0;
   bit long_hold = 1'b0;

   weighted_over_accumulate_core dut (.*);

   always #4 clock = ~clock;

   // Random result-side stall; one long hold-off on request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            blend_sb.check_result('{rsp_out_index, rsp_acc_red, rsp_acc_green,
                                    rsp_acc_blue, rsp_acc_alpha});
         if (long_hold) begin
            hold_cycles <= 200;
            long_hold <= 1'b0;
            rsp_stall <= 1'b1;
         end else if (hold_cycles > 1) begin
            hold_cycles <= hold_cycles - 1;
         end else begin
            hold_cycles <= 0;
            case ($urandom_range(0, 9))
               0, 1:    rsp_stall <= 1'b1;
               default: rsp_stall <= ($urandom_range(0, 199) == 0) ? 1'b1 : 1'b0;
            endcase
         end
      end
   end

   task automatic write_sample_count(logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= woa_pkg::CSR_AW'(4 * woa_pkg::REG_SAMPLE_COUNT);
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      blend_sb.weight_count = value;
   endtask

   task automatic send_sample(logic [15:0] idx, logic first, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b, logic [7:0] a, bit gaps);
      int gap;
      gap = 0;
      if (gaps)
         gap = ($urandom_range(0, 9) < 7) ? 0 :
               ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
      // drop valid during the gap so the last transfer is not offered again
      if (gap > 0)
         req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_pixel_index <= idx;
      req_first_sample <= first;
      req_src_red <= r;
      req_src_green <= g;
      req_src_blue <= b;
      req_src_alpha <= a;
      do @(posedge clock); while (req_stall);
      blend_sb.note_sample(idx, first, r, g, b, a);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      int guard;
      guard = 0;
      while (blend_sb.pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic random_burst(int count, int pool);
      logic [15:0] idx;
      for (int k = 0; k < count; k++) begin
         // Mostly revisit a small pixel set so blends accumulate and hazards occur.
         idx = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, pool));
         send_sample(idx, $urandom_range(0, 5) == 0, 8'($urandom), 8'($urandom),
                     8'($urandom), ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom), 1'b1);
         if ($urandom_range(0, 3) == 0) begin
            drop_valid();
            @(posedge clock);
         end
      end
      drop_valid();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes, transparent result, zero count, same-pixel chains.
      send_sample(16'd0, 1'b1, 8'd255, 8'd0, 8'd128, 8'd255, 1'b0);
      send_sample(16'd0, 1'b0, 8'd0, 8'd255, 8'd1, 8'd128, 1'b0);
      send_sample(16'd0, 1'b0, 8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
      send_sample(16'd0, 1'b1, 8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
      send_sample(16'hFFFF, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_sample(16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0);
      send_sample(16'h5555, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
      send_sample(16'hAAAA, 1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
      send_sample(16'h5555, 1'b0, 8'h01, 8'h02, 8'h03, 8'h7F, 1'b0);
      drop_valid();
      wait_drain();
      write_sample_count(8'd0);
      send_sample(16'd7, 1'b1, 8'd200, 8'd100, 8'd50, 8'd255, 1'b0);
      send_sample(16'd7, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
      drop_valid();
      wait_drain();
      write_sample_count(8'd255);
      send_sample(16'd8, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_sample(16'd8, 1'b0, 8'd255, 8'd255, 8'd255, 8'd254, 1'b0);
      send_sample(16'd8, 1'b0, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0);
      drop_valid();
      wait_drain();
      write_sample_count(8'd1);
      long_hold <= 1'b1;
      random_burst(250, 15);
      wait_drain();
      write_sample_count(8'd4);
      random_burst(250, 31);
      wait_drain();
      write_sample_count(8'd255);
      random_burst(200, 7);
      wait_drain();
      write_sample_count(8'($urandom_range(2, 254)));
      random_burst(200, 63);
      wait_drain();
      write_sample_count(8'd1);
      random_burst(130, 3);
      wait_drain();
      if (blend_sb.errors == 0 && blend_sb.pending.size() == 0)
         $display("weighted_over_accumulate_core regression: pass");
      else
         $display("weighted_over_accumulate_core regression: fail");
      $finish;
   end

   initial begin
      #8000000;
      $display("weighted_over_accumulate_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ----- weighted_over_accumulate_core.f -----
+incdir+rtl
rtl/woa_pkg.sv
rtl/woa_store.sv
rtl/woa_blend.sv
rtl/weighted_over_accumulate_core.sv
bench/tb.sv
